// ===== rtl/core/twims_pkg.sv =====
package twims_pkg;

    // Default buffer depths.
    localparam int WRITE_DEPTH_DEF = 16;
    localparam int READ_DEPTH_DEF  = 16;

    // Request types.
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_EVENT = 2'd1;
    localparam logic [1:0] REQ_LOAD  = 2'd2;

    // Bus commands.
    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_ADDR     = 3'd1;
    localparam logic [2:0] CMD_DATA     = 3'd2;
    localparam logic [2:0] CMD_STOP     = 3'd3;
    localparam logic [2:0] CMD_ACKRX    = 3'd4;
    localparam logic [2:0] CMD_NACKSTOP = 3'd5;

    // Result codes.
    localparam logic [2:0] RES_UNKNOWN  = 3'd0;
    localparam logic [2:0] RES_OK       = 3'd1;
    localparam logic [2:0] RES_BUSERR   = 3'd2;
    localparam logic [2:0] RES_ARBLOST  = 3'd3;
    localparam logic [2:0] RES_NACK     = 3'd4;
    localparam logic [2:0] RES_OVERFLOW = 3'd5;
    localparam logic [2:0] RES_FAIL     = 3'd6;

    // R/W bit of the address byte.
    localparam logic RW_READ  = 1'b1;
    localparam logic RW_WRITE = 1'b0;

    // Response of one item, before the write-buffer data is merged in.
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] data_byte;
        logic       data_sel;
        logic       busy;
        logic [2:0] result;
        logic       fin;
        logic       acc;
        logic       rxv;
        logic [3:0] rxi;
    } resp_t;

endpackage

// ===== rtl/core/twims_ram.sv =====
module twims_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/twims_ctrl.sv =====
module twims_ctrl
    import twims_pkg::*;
#(
    parameter int WRITE_DEPTH = WRITE_DEPTH_DEF,
    parameter int READ_DEPTH  = READ_DEPTH_DEF,
    localparam int WAW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1,
    localparam int RAW = (READ_DEPTH > 1) ? $clog2(READ_DEPTH) : 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  logic [1:0]     req_type,
    input  logic [6:0]     target_address,
    input  logic [4:0]     write_count,
    input  logic [7:0]     read_count,
    input  logic [3:0]     load_index,
    input  logic           bus_error,
    input  logic           arb_lost,
    input  logic           write_flag,
    input  logic           read_flag,
    input  logic           rx_nack,
    output resp_t          rsp,
    output logic           wb_rd_en,
    output logic [WAW-1:0] wb_rd_addr,
    output logic           wb_wr_en,
    output logic [WAW-1:0] wb_wr_addr,
    output logic           rb_wr_en,
    output logic [RAW-1:0] rb_wr_addr
);

    // Read count must hold READ_DEPTH itself.
    localparam int RDW = $clog2(READ_DEPTH + 1);

    logic           busy_reg, busy_next;
    logic [2:0]     result_reg, result_next;
    logic [6:0]     addr_reg, addr_next;
    logic [4:0]     wtotal_reg, wtotal_next;
    logic [7:0]     rtotal_reg, rtotal_next;
    logic [4:0]     written_reg, written_next;
    logic [RDW-1:0] rdone_reg, rdone_next;

    logic [8:0]     written_ext;
    logic [8:0]     rdone_ext;
    logic [8:0]     rdone_inc_ext;
    logic [8:0]     load_ext;
    logic [4:0]     wc_sat;
    logic           wb_rd_req;
    logic           wb_wr_req;
    logic           rb_wr_req;

    assign written_ext   = {4'd0, written_reg};
    assign rdone_ext     = 9'(rdone_reg);
    assign rdone_inc_ext = rdone_ext + 9'd1;
    assign load_ext      = {5'd0, load_index};
    assign wc_sat        = ({4'd0, write_count} > 9'(WRITE_DEPTH)) ? 5'(WRITE_DEPTH)
                                                                   : write_count;

    assign wb_rd_addr = written_ext[WAW-1:0];
    assign wb_wr_addr = load_ext[WAW-1:0];
    assign rb_wr_addr = rdone_ext[RAW-1:0];

    // Decision for one item and the next scalar state.
    always_comb
    begin
        busy_next    = busy_reg;
        result_next  = result_reg;
        addr_next    = addr_reg;
        wtotal_next  = wtotal_reg;
        rtotal_next  = rtotal_reg;
        written_next = written_reg;
        rdone_next   = rdone_reg;
        wb_rd_req    = 1'b0;
        wb_wr_req    = 1'b0;
        rb_wr_req    = 1'b0;
        rsp          = '0;
        rsp.cmd      = CMD_NONE;

        unique case (req_type)
            REQ_START:
            begin
                if (!busy_reg)
                begin
                    rsp.acc      = 1'b1;
                    busy_next    = 1'b1;
                    result_next  = RES_UNKNOWN;
                    addr_next    = target_address;
                    wtotal_next  = wc_sat;
                    rtotal_next  = read_count;
                    written_next = '0;
                    rdone_next   = '0;
                    if (wc_sat != 5'd0)
                    begin
                        rsp.cmd       = CMD_ADDR;
                        rsp.data_byte = {target_address, RW_WRITE};
                    end
                    else if (read_count != 8'd0)
                    begin
                        rsp.cmd       = CMD_ADDR;
                        rsp.data_byte = {target_address, RW_READ};
                    end
                    else
                    begin
                        // Nothing to move: done at once.
                        busy_next   = 1'b0;
                        result_next = RES_OK;
                        rsp.fin     = 1'b1;
                    end
                end
            end
            REQ_EVENT:
            begin
                if (busy_reg)
                begin
                    if (bus_error)
                    begin
                        busy_next   = 1'b0;
                        result_next = RES_BUSERR;
                    end
                    else if (arb_lost)
                    begin
                        busy_next   = 1'b0;
                        result_next = RES_ARBLOST;
                    end
                    else if (write_flag)
                    begin
                        if (rx_nack)
                        begin
                            rsp.cmd     = CMD_STOP;
                            busy_next   = 1'b0;
                            result_next = RES_NACK;
                        end
                        else if (written_reg < wtotal_reg)
                        begin
                            // Data byte comes from the write buffer next cycle.
                            rsp.cmd      = CMD_DATA;
                            rsp.data_sel = 1'b1;
                            wb_rd_req    = 1'b1;
                            written_next = written_reg + 5'd1;
                        end
                        else if ({1'b0, rdone_ext[7:0]} < {1'b0, rtotal_reg}
                                 && rdone_ext[8] == 1'b0)
                        begin
                            // Repeated start for the read phase.
                            rsp.cmd       = CMD_ADDR;
                            rsp.data_byte = {addr_reg, RW_READ};
                        end
                        else
                        begin
                            rsp.cmd     = CMD_STOP;
                            busy_next   = 1'b0;
                            result_next = RES_OK;
                            rsp.fin     = 1'b1;
                        end
                    end
                    else if (read_flag)
                    begin
                        if (rdone_ext >= 9'(READ_DEPTH))
                        begin
                            // Read buffer full: drop the byte and stop.
                            rsp.cmd     = CMD_STOP;
                            busy_next   = 1'b0;
                            result_next = RES_OVERFLOW;
                        end
                        else
                        begin
                            rb_wr_req  = 1'b1;
                            rsp.rxv    = 1'b1;
                            rsp.rxi    = rdone_ext[3:0];
                            rdone_next = rdone_inc_ext[RDW-1:0];
                            if (rdone_inc_ext < {1'b0, rtotal_reg})
                            begin
                                rsp.cmd = CMD_ACKRX;
                            end
                            else
                            begin
                                rsp.cmd     = CMD_NACKSTOP;
                                busy_next   = 1'b0;
                                result_next = RES_OK;
                                rsp.fin     = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        // Event with no flag set.
                        busy_next   = 1'b0;
                        result_next = RES_FAIL;
                    end
                end
            end
            REQ_LOAD:
            begin
                if (load_ext < 9'(WRITE_DEPTH))
                begin
                    wb_wr_req = 1'b1;
                end
            end
            default:
            begin
                // Unused request type: no effect.
            end
        endcase

        rsp.busy   = busy_next;
        rsp.result = result_next;
    end

    assign wb_rd_en = fire & wb_rd_req;
    assign wb_wr_en = fire & wb_wr_req;
    assign rb_wr_en = fire & rb_wr_req;

    // Scalar transaction state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            result_reg  <= RES_UNKNOWN;
            addr_reg    <= '0;
            wtotal_reg  <= '0;
            rtotal_reg  <= '0;
            written_reg <= '0;
            rdone_reg   <= '0;
        end
        else if (fire)
        begin
            busy_reg    <= busy_next;
            result_reg  <= result_next;
            addr_reg    <= addr_next;
            wtotal_reg  <= wtotal_next;
            rtotal_reg  <= rtotal_next;
            written_reg <= written_next;
            rdone_reg   <= rdone_next;
        end
    end

endmodule

// ===== rtl/core/twi_master_transaction_sequencer.sv =====
// I2C master write-then-read sequencer. Each transfer on the input channel (a start
// request, a bus status event or a write-buffer load) yields exactly one transfer on
// the output channel carrying the bus command to issue next, the busy flag and the
// result code. The block takes one item per clock cycle while the output does not
// stall; each result is registered in the output register, alongside the registered
// read of the write-buffer RAM that supplies data bytes. The output register holds
// one result; the input is stalled only while that result is held back by a stall on
// the output side. Write and read buffers are RAMs with one write port and one
// registered read port, of WRITE_DEPTH and READ_DEPTH bytes, and are not cleared by
// reset, so the write buffer slots to be sent must be loaded first.
module twi_master_transaction_sequencer
    import twims_pkg::*;
#(
    parameter int WRITE_DEPTH = WRITE_DEPTH_DEF,
    parameter int READ_DEPTH  = READ_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] req_type,
    input  logic [6:0] target_address,
    input  logic [4:0] write_count,
    input  logic [7:0] read_count,
    input  logic [3:0] load_index,
    input  logic [7:0] load_byte,
    input  logic       bus_error,
    input  logic       arb_lost,
    input  logic       write_flag,
    input  logic       read_flag,
    input  logic       rx_nack,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] bus_command,
    output logic [7:0] bus_byte,
    output logic       busy_res,
    output logic [2:0] result_code,
    output logic       finished,
    output logic       start_accepted,
    output logic       rx_valid,
    output logic [3:0] rx_index
);

    localparam int WAW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
    localparam int RAW = (READ_DEPTH > 1) ? $clog2(READ_DEPTH) : 1;

    logic           fire;
    resp_t          rsp;
    resp_t          rsp_reg;
    logic           out_valid_reg;
    logic           wb_rd_en;
    logic [WAW-1:0] wb_rd_addr;
    logic           wb_wr_en;
    logic [WAW-1:0] wb_wr_addr;
    logic [7:0]     wb_rd_data;
    logic           rb_wr_en;
    logic [RAW-1:0] rb_wr_addr;

    // The output register frees up when its result is taken.
    assign in_stall = out_valid_reg & out_stall;
    assign fire     = in_valid & ~in_stall;

    twims_ctrl #(
        .WRITE_DEPTH (WRITE_DEPTH),
        .READ_DEPTH  (READ_DEPTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .req_type       (req_type),
        .target_address (target_address),
        .write_count    (write_count),
        .read_count     (read_count),
        .load_index     (load_index),
        .bus_error      (bus_error),
        .arb_lost       (arb_lost),
        .write_flag     (write_flag),
        .read_flag      (read_flag),
        .rx_nack        (rx_nack),
        .rsp            (rsp),
        .wb_rd_en       (wb_rd_en),
        .wb_rd_addr     (wb_rd_addr),
        .wb_wr_en       (wb_wr_en),
        .wb_wr_addr     (wb_wr_addr),
        .rb_wr_en       (rb_wr_en),
        .rb_wr_addr     (rb_wr_addr)
    );

    // Write buffer: loads write, data sends read.
    twims_ram #(
        .WIDTH (8),
        .DEPTH (WRITE_DEPTH)
    ) u_wbuf (
        .clk     (clk),
        .wr_en   (wb_wr_en),
        .wr_addr (wb_wr_addr),
        .wr_data (load_byte),
        .rd_en   (wb_rd_en),
        .rd_addr (wb_rd_addr),
        .rd_data (wb_rd_data)
    );

    // Read buffer: stores each received byte at its slot.
    twims_ram #(
        .WIDTH (8),
        .DEPTH (READ_DEPTH)
    ) u_rbuf (
        .clk     (clk),
        .wr_en   (rb_wr_en),
        .wr_addr (rb_wr_addr),
        .wr_data (rx_byte),
        .rd_en   (1'b0),
        .rd_addr ('0),
        .rd_data ()
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= rsp;
        end
    end

    // The RAM read data holds while stalled since its read is tied to acceptance.
    assign out_valid      = out_valid_reg;
    assign bus_command    = rsp_reg.cmd;
    assign bus_byte       = rsp_reg.data_sel ? wb_rd_data : rsp_reg.data_byte;
    assign busy_res       = rsp_reg.busy;
    assign result_code    = rsp_reg.result;
    assign finished       = rsp_reg.fin;
    assign start_accepted = rsp_reg.acc;
    assign rx_valid       = rsp_reg.rxv;
    assign rx_index       = rsp_reg.rxi;

    // A completion always leaves the block idle with an OK result.
    a_fin_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> !busy_res && result_code == RES_OK)
        else $error("finished without idle OK state");

    // A stored byte is always answered by ack or nack on the bus.
    a_rx_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rx_valid |-> bus_command == CMD_ACKRX || bus_command == CMD_NACKSTOP)
        else $error("received byte without receive command");

    // A data byte is only sent within a running transaction.
    a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bus_command == CMD_DATA |-> busy_res && !start_accepted)
        else $error("data byte outside a transaction");

    // An accepted start with no bus command is the zero-length case.
    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && start_accepted && bus_command == CMD_NONE |-> finished)
        else $error("accepted start issued no command and did not finish");

endmodule
